@@ rtl/pts_pkg.sv @@
`timescale 1ns / 1ps
// pts_pkg: shared constants, codes and types of the periodic timer slot table
// no dependencies

package pts_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int NF_W           = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W         = 32;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_TICK  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        OC_STARTED       = 3'd0,
        OC_START_REFUSED = 3'd1,
        OC_FULL          = 3'd2,
        OC_STOPPED       = 3'd3,
        OC_STOP_REFUSED  = 3'd4,
        OC_FIRED         = 3'd5
    } t_outcome;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_TICK
    } t_state;

    localparam logic REG_ENABLE = 1'b0;

endpackage

@@ rtl/pts_ram.sv @@
`timescale 1ns / 1ps
// pts_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module pts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/periodic_timer_slot_table.sv @@
`timescale 1ns / 1ps
// periodic_timer_slot_table: table of periodic timer slots with start, stop and tick
// depends on pts_pkg and pts_ram
//
// An item is taken when start is high and busy is low; busy stays high until the
// item is finished. A stop needs no search; its result is registered directly. A start
// walks the active bits one slot a cycle to find the lowest free slot. A tick sweeps
// every slot through the single read port of the interval/expiry ram and one shared
// compare and adder, one slot a cycle. Each result shows for exactly one cycle with
// o_result_strobe high and cannot be held off; a tick gives one beat per fired slot
// (at most eight), the last beat flagged by o_last_of_run, and a tick that fires
// nothing gives no beat. Writing 1 to the enable register clears every slot at once,
// writing 0 disables the table; write it only while busy is low.

module periodic_timer_slot_table #(
    parameter int SLOT_COUNT = pts_pkg::SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_interval_ms,
    input  logic [3:0]  i_stop_slot,
    input  logic [31:0] i_now_ms,
    // results
    output logic        o_result_strobe,
    output logic [2:0]  o_outcome,
    output logic [2:0]  o_slot,
    output logic        o_last_of_run,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import pts_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    t_state                r_state, n_state;
    logic                  r_enabled, n_enabled;
    logic [SLOT_COUNT-1:0] r_active, n_active;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic                  r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx, n_cmp_idx;
    logic [TIME_W-1:0]     r_now, n_now;
    logic [TIME_W-1:0]     r_interval, n_interval;
    logic                  r_pend_vld, n_pend_vld;
    logic [IDX_W-1:0]      r_pend_idx, n_pend_idx;
    logic [NF_W-1:0]       r_nfire, n_nfire;
    logic                  r_strobe, n_strobe;
    logic [2:0]            r_outcome, n_outcome;
    logic [2:0]            r_slot, n_slot;
    logic                  r_last, n_last;

    logic                  w_accept;
    logic                  w_cfg_wr;
    t_action               w_action;
    logic [IDX_W-1:0]      w_stop_idx;
    logic                  w_stop_ok;
    logic [IDX_W-1:0]      w_find_idx;
    logic                  w_sweep_end;

    // shared arithmetic
    logic [TIME_W-1:0]     w_add_b;
    logic [TIME_W-1:0]     w_sum;
    logic                  w_due;

    // interval/expiry ram
    logic                  w_wr_en;
    logic [IDX_W-1:0]      w_wr_addr;
    logic [2*TIME_W-1:0]   w_wr_data;
    logic                  w_rd_en;
    logic [2*TIME_W-1:0]   w_rd_data;
    logic [TIME_W-1:0]     w_rd_interval;
    logic [TIME_W-1:0]     w_rd_expiry;

    pts_ram #(
        .WIDTH(2 * TIME_W),
        .DEPTH(SLOT_COUNT)
    ) u_slot_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(r_idx[IDX_W-1:0]),
        .o_rd_data(w_rd_data)
    );

    assign w_rd_interval = w_rd_data[2*TIME_W-1:TIME_W];
    assign w_rd_expiry   = w_rd_data[TIME_W-1:0];

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_action = t_action'(i_action);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    assign w_stop_idx  = IDX_W'(i_stop_slot);
    assign w_stop_ok   = r_enabled && (32'(i_stop_slot) < 32'(SLOT_COUNT))
                         && r_active[w_stop_idx];
    assign w_find_idx  = r_idx[IDX_W-1:0];
    assign w_sweep_end = (r_idx == CNT_W'(SLOT_COUNT)) && !r_cmp_vld;

    assign w_add_b = (r_state == S_TICK) ? w_rd_interval : r_interval;
    assign w_sum   = r_now + w_add_b;
    assign w_due   = r_cmp_vld && r_active[r_cmp_idx] && (r_now >= w_rd_expiry)
                     && (r_nfire < NF_W'(MAX_RESULTS));

    assign w_rd_en = (r_state == S_TICK) && (r_idx != CNT_W'(SLOT_COUNT));

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = w_find_idx;
        w_wr_data = {r_interval, w_sum};
        if (r_state == S_FIND && r_idx != CNT_W'(SLOT_COUNT) && !r_active[w_find_idx]) begin
            w_wr_en = 1'b1;
        end else if (r_state == S_TICK && w_due) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_cmp_idx;
            w_wr_data = {w_rd_interval, w_sum};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_action)
                        ACT_START: begin
                            if (r_enabled && i_interval_ms != '0) begin
                                n_state = S_FIND;
                            end
                        end
                        ACT_TICK: begin
                            if (r_enabled) begin
                                n_state = S_TICK;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_FIND: begin
                if (r_idx == CNT_W'(SLOT_COUNT) || !r_active[w_find_idx]) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                if (w_sweep_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and results
    always_comb begin
        n_enabled  = r_enabled;
        n_active   = r_active;
        n_idx      = r_idx;
        n_cmp_vld  = 1'b0;
        n_cmp_idx  = r_cmp_idx;
        n_now      = r_now;
        n_interval = r_interval;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        n_nfire    = r_nfire;
        n_strobe   = 1'b0;
        n_outcome  = r_outcome;
        n_slot     = r_slot;
        n_last     = r_last;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_now      = i_now_ms;
                    n_interval = i_interval_ms;
                    n_idx      = '0;
                    n_pend_vld = 1'b0;
                    n_nfire    = '0;
                    case (w_action)
                        ACT_START: begin
                            if (!r_enabled || i_interval_ms == '0) begin
                                n_strobe  = 1'b1;
                                n_outcome = OC_START_REFUSED;
                                n_slot    = '0;
                                n_last    = 1'b1;
                            end
                        end
                        ACT_STOP: begin
                            n_strobe = 1'b1;
                            n_last   = 1'b1;
                            if (w_stop_ok) begin
                                n_active[w_stop_idx] = 1'b0;
                                n_outcome = OC_STOPPED;
                                n_slot    = 3'(i_stop_slot);
                            end else begin
                                n_outcome = OC_STOP_REFUSED;
                                n_slot    = '0;
                            end
                        end
                        default: n_strobe = 1'b0;
                    endcase
                end
            end
            S_FIND: begin
                if (r_idx == CNT_W'(SLOT_COUNT)) begin
                    n_strobe  = 1'b1;
                    n_outcome = OC_FULL;
                    n_slot    = '0;
                    n_last    = 1'b1;
                end else if (!r_active[w_find_idx]) begin
                    n_active[w_find_idx] = 1'b1;
                    n_strobe  = 1'b1;
                    n_outcome = OC_STARTED;
                    n_slot    = 3'(w_find_idx);
                    n_last    = 1'b1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TICK: begin
                // read slot r_idx while slot r_cmp_idx is compared
                if (r_idx != CNT_W'(SLOT_COUNT)) begin
                    n_idx     = r_idx + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[IDX_W-1:0];
                end
                // a fired slot is held pending until the next fire or the sweep end so the final beat can be flagged
                if (w_due) begin
                    n_nfire    = r_nfire + 1'b1;
                    n_pend_vld = 1'b1;
                    n_pend_idx = r_cmp_idx;
                    if (r_pend_vld) begin
                        n_strobe  = 1'b1;
                        n_outcome = OC_FIRED;
                        n_slot    = 3'(r_pend_idx);
                        n_last    = 1'b0;
                    end
                end else if (w_sweep_end && r_pend_vld) begin
                    n_pend_vld = 1'b0;
                    n_strobe   = 1'b1;
                    n_outcome  = OC_FIRED;
                    n_slot     = 3'(r_pend_idx);
                    n_last     = 1'b1;
                end
            end
            default: n_strobe = 1'b0;
        endcase

        if (w_cfg_wr && paddr[2] == REG_ENABLE) begin
            if (pwdata[0]) begin
                n_enabled = 1'b1;
                n_active  = '0;
            end else begin
                n_enabled = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_enabled  <= 1'b0;
            r_active   <= '0;
            r_idx      <= '0;
            r_cmp_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_nfire    <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_enabled  <= n_enabled;
            r_active   <= n_active;
            r_idx      <= n_idx;
            r_cmp_vld  <= n_cmp_vld;
            r_pend_vld <= n_pend_vld;
            r_nfire    <= n_nfire;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_now      <= n_now;
        r_interval <= n_interval;
        r_pend_idx <= n_pend_idx;
        r_outcome  <= n_outcome;
        r_slot     <= n_slot;
        r_last     <= n_last;
    end

    assign o_result_strobe = r_strobe;
    assign o_outcome       = r_outcome;
    assign o_slot          = r_slot;
    assign o_last_of_run   = r_last;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENABLE) ? {31'd0, r_enabled} : 32'd0;

endmodule
